// ===== hw/rtl/frwl_pkg.sv =====
// Package for the fair reader/writer lock manager.
// Holds the request and outcome codes and the fixed field widths.
// No dependencies.
package frwl_pkg;

   localparam int MODE_W    = 2;
   localparam int OUTCOME_W = 3;
   localparam int ID_W      = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOCK_SHARED   = 2'd0,
      MODE_LOCK_EXCL     = 2'd1,
      MODE_UNLOCK_SHARED = 2'd2,
      MODE_UNLOCK_EXCL   = 2'd3
   } mode_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OC_GRANTED  = 3'd0,
      OC_QUEUED   = 3'd1,
      OC_RELEASED = 3'd2,
      OC_MISMATCH = 3'd3,
      OC_FULL     = 3'd4,
      OC_OVERFLOW = 3'd5
   } outcome_type;

endpackage

// ===== hw/rtl/fair_reader_writer_lock.sv =====
// Fair (FIFO) reader/writer lock manager. Depends on frwl_pkg and frwl_ram.
// A request's first result is valid the cycle after its transfer. A wake takes each shared
// waiter granted through grant, queue read, look-ahead and result, and the final grant
// through grant and result; the queue read is paced by the registered read port of the queue.
// The block takes one item at a time; req_stall is high until its last result is taken.
// Reset (synchronous, active high) empties the queue and frees the lock; queue RAM not cleared.
module fair_reader_writer_lock #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int MAX_SHARED  = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [frwl_pkg::MODE_W-1:0]        req_mode,
   input  logic [frwl_pkg::ID_W-1:0]          req_requester,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [frwl_pkg::OUTCOME_W-1:0]     rsp_outcome,
   output logic [frwl_pkg::ID_W-1:0]          rsp_granted_id,
   output logic                               rsp_granted_exclusive,
   output logic                               rsp_last
);

   import frwl_pkg::*;

   // Only the low ID bits are kept; ids never exceed the 8-bit field.
   localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int EW  = IDW + 1;                       // id plus mode bit on top
   localparam int QIW = $clog2(QUEUE_DEPTH);           // queue index
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);       // queue fill count
   localparam int HW  = $clog2(MAX_SHARED + 1);        // shared holder count

   // Sequencer: IDLE takes a request; GRANT pops the head waiter; PEEK waits on the
   // queue read of the new head; LOOK decides whether the wake goes on; RESULT holds
   // a result until the transfer.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RESULT = 5'b00010,
      ST_GRANT  = 5'b00100,
      ST_PEEK   = 5'b01000,
      ST_LOOK   = 5'b10000
   } state_type;

   state_type   state_ff,     state_in;
   logic        held_excl_ff, held_excl_in;
   logic [HW-1:0]  holders_ff, holders_in;
   logic [QIW-1:0] head_ff,    head_in;
   logic [QIW-1:0] tail_ff,    tail_in;
   logic [QCW-1:0] count_ff,   count_in;
   logic        wake_ff,      wake_in;

   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type rsp_outcome_ff, rsp_outcome_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic        rsp_excl_ff,  rsp_excl_in;
   logic        rsp_last_ff,  rsp_last_in;

   // Wait queue port
   logic           ram_wr_en;
   logic [EW-1:0]  ram_wr_data;
   logic [EW-1:0]  ram_rd_data;

   logic req_xfer, rsp_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   frwl_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic          q_empty;
      logic          q_full;
      logic          enq;
      logic          enq_excl;
      logic [IDW-1:0] req_id;
      logic [IDW-1:0] head_id;
      logic          head_excl;
      logic [QIW-1:0] head_next;
      logic [QIW-1:0] tail_next;

      state_in       = state_ff;
      held_excl_in   = held_excl_ff;
      holders_in     = holders_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      wake_in        = wake_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_excl_in    = rsp_excl_ff;
      rsp_last_in    = rsp_last_ff;

      q_empty   = (count_ff == '0);
      q_full    = (count_ff >= QCW'(QUEUE_DEPTH));
      req_id    = req_requester[IDW-1:0];
      head_id   = ram_rd_data[IDW-1:0];
      head_excl = ram_rd_data[IDW];
      head_next = (head_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tail_next = (tail_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      enq       = 1'b0;
      enq_excl  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_valid_in   = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_id_in      = '0;
               rsp_excl_in    = 1'b0;
               rsp_outcome_in = OC_MISMATCH;
               wake_in        = 1'b0;
               state_in       = ST_RESULT;
               case (mode_type'(req_mode))
                  MODE_LOCK_SHARED: begin
                     rsp_id_in = ID_W'(req_id);
                     if (!q_empty || held_excl_ff) begin
                        enq = 1'b1;
                     end else if (holders_ff >= HW'(MAX_SHARED)) begin
                        rsp_outcome_in = OC_OVERFLOW;
                     end else begin
                        holders_in     = holders_ff + 1'b1;
                        rsp_outcome_in = OC_GRANTED;
                     end
                  end
                  MODE_LOCK_EXCL: begin
                     rsp_id_in   = ID_W'(req_id);
                     rsp_excl_in = 1'b1;
                     if (q_empty && !held_excl_ff && holders_ff == '0) begin
                        held_excl_in   = 1'b1;
                        rsp_outcome_in = OC_GRANTED;
                     end else begin
                        enq      = 1'b1;
                        enq_excl = 1'b1;
                     end
                  end
                  MODE_UNLOCK_SHARED: begin
                     if (!held_excl_ff && holders_ff != '0) begin
                        holders_in     = holders_ff - 1'b1;
                        rsp_outcome_in = OC_RELEASED;
                        // last reader out with waiters: the head is always grantable
                        wake_in        = (holders_ff == HW'(1)) && !q_empty;
                        rsp_last_in    = !wake_in;
                     end
                  end
                  default: begin
                     if (held_excl_ff) begin
                        held_excl_in   = 1'b0;
                        rsp_outcome_in = OC_RELEASED;
                        wake_in        = !q_empty;
                        rsp_last_in    = q_empty;
                     end
                  end
               endcase
               if (enq) begin
                  if (q_full) begin
                     rsp_outcome_in = OC_FULL;
                  end else begin
                     tail_in        = tail_next;
                     count_in       = count_ff + 1'b1;
                     rsp_outcome_in = OC_QUEUED;
                  end
               end
            end
         end

         ST_RESULT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               state_in     = wake_ff ? ST_GRANT : ST_IDLE;
            end
         end

         ST_GRANT: begin
            // Pop the head waiter; unless it ends the wake, the result waits in the output
            // register until the look-ahead settles its last flag.
            head_in        = head_next;
            count_in       = count_ff - 1'b1;
            rsp_outcome_in = OC_GRANTED;
            rsp_id_in      = ID_W'(head_id);
            rsp_excl_in    = head_excl;
            if (head_excl) begin
               held_excl_in = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               wake_in      = 1'b0;
               state_in     = ST_RESULT;
            end else begin
               holders_in = holders_ff + 1'b1;
               if (count_ff == QCW'(1) || holders_ff >= HW'(MAX_SHARED - 1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  wake_in      = 1'b0;
                  state_in     = ST_RESULT;
               end else begin
                  state_in = ST_PEEK;
               end
            end
         end

         ST_PEEK: begin
            state_in = ST_LOOK;
         end

         ST_LOOK: begin
            // Shared holders remain, so only a shared head keeps the wake going.
            wake_in      = !head_excl;
            rsp_last_in  = head_excl;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESULT;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ram_wr_en   = enq && !q_full;
      ram_wr_data = {enq_excl, req_id};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_excl_ff <= 1'b0;
         holders_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         wake_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_excl_ff <= held_excl_in;
         holders_ff   <= holders_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         wake_ff      <= wake_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded only while no result is on offer
   always_ff @(posedge clock) begin
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_excl_ff    <= rsp_excl_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_outcome           = rsp_outcome_ff;
   assign rsp_granted_id        = rsp_id_ff;
   assign rsp_granted_exclusive = rsp_excl_ff;
   assign rsp_last              = rsp_last_ff;

   // A result is on offer exactly while the sequencer sits in RESULT.
   a_valid_in_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_RESULT))
      else $error("result valid outside RESULT state");

   // Exclusive ownership and shared holders never coexist.
   a_excl_no_readers: assert property (@(posedge clock) disable iff (reset)
      !(held_excl_ff && holders_ff != '0))
      else $error("exclusive holder alongside shared holders");

   // A wake only pops from a non-empty queue.
   a_grant_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRANT) |-> (count_ff != '0))
      else $error("wake grant from empty queue");

   // The fill count stays within the queue.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/frwl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the lock manager's wait queue. No dependencies.
module frwl_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
